@@ rtl/core/simple_moving_average_macros.svh @@
// Assertion macros shared by the moving average RTL.
// Needs clk and rst_n in scope at the point of use; no other dependencies.
`ifndef SIMPLE_MOVING_AVERAGE_MACROS_SVH
`define SIMPLE_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, masked while in reset
`define SMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while in reset
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sma_pkg.sv @@
// Shared types and defaults for the moving average block.
// No dependencies; compile first after the macro header.
package sma_pkg;

  localparam int WINDOW_DEF      = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV
  } sma_state_t;

  // divider status seen by the control FSM
  typedef struct packed {
    logic busy;
    logic done;
  } sma_div_stat_t;

endpackage

@@ rtl/core/sma_if.sv @@
// Valid/ready channel interfaces for the moving average block.
// Standalone; widths come from the SAMPLE_BITS parameter.
interface sma_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sma_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

@@ rtl/core/sma_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module sma_ram #(
  parameter  int WIDTH     = 16,
  parameter  int DEPTH     = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/sma_div.sv @@
// Radix-2 restoring divider: signed dividend by unsigned nonzero divisor,
// one quotient bit per cycle, result truncated toward zero. Uses sma_pkg.
module sma_div #(
  parameter int DIVIDEND_BITS = 20,
  parameter int DIVISOR_BITS  = 5,
  parameter int QUO_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]         divisor,
  output logic signed [QUO_BITS-1:0]      quotient,
  output sma_pkg::sma_div_stat_t          stat
);
  import sma_pkg::*;

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_BITS-1:0] mag_r, mag_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0]  den_r, den_nxt;
  logic                     neg_r, neg_nxt;

  logic [DIVIDEND_BITS-1:0] dvd_u;
  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;
  logic [QUO_BITS-1:0]      q_u;

  assign dvd_u   = dividend;
  assign shifted = {rem_r, mag_r[DIVIDEND_BITS-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = (shifted >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_BITS'(DIVIDEND_BITS);
      mag_nxt  = dvd_u[DIVIDEND_BITS-1] ? (~dvd_u + DIVIDEND_BITS'(1)) : dvd_u;
      rem_nxt  = '0;
      den_nxt  = divisor;
      neg_nxt  = dvd_u[DIVIDEND_BITS-1];
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back in DIVISOR_BITS
      rem_nxt = ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      mag_nxt = {mag_r[DIVIDEND_BITS-2:0], ge};
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // |quotient| <= 2^(QUO_BITS-1), so the low bits hold it exactly
  assign q_u       = mag_r[QUO_BITS-1:0];
  assign quotient  = $signed(neg_r ? (~q_u + QUO_BITS'(1)) : q_u);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/core/simple_moving_average.sv @@
// Simple moving average top level: ring RAM, running total, serial divider.
// Depends on sma_pkg, sma_in_if/sma_out_if, sma_ram, sma_div and the macro header.
//
// Each accepted item carries one signed sample; the block answers with one
// item holding the mean of the last WINDOW samples (fewer right after reset,
// when the divisor is the number of samples seen so far), truncated toward
// zero. One item is worked on at a time: it passes the UPDATE state, where the
// ring and running total change, then the DIV state until the divider is done.
// The pace is set by the divider, which makes one quotient bit per cycle.
// The result sits in an output register, so a new sample is taken while the
// previous average still waits for the sink. No clearing pass follows reset:
// ring entries not yet written are treated as zero via the fill count.
`include "simple_moving_average_macros.svh"

module simple_moving_average #(
  parameter int WINDOW      = sma_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  sma_in_if.sink   in_chan,
  sma_out_if.source out_chan
);
  import sma_pkg::*;

  localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  // exact sum of WINDOW samples
  localparam int TOT_BITS  = SAMPLE_BITS + $clog2(WINDOW);

  sma_state_t state_r, state_nxt;

  logic signed [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [SLOT_BITS-1:0]          slot_r, slot_nxt;
  logic [CNT_BITS-1:0]           fill_r, fill_nxt;
  logic signed [TOT_BITS-1:0]    total_r, total_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_avg_r, out_avg_nxt;

  logic in_fire;
  logic in_ready;
  logic ram_re;
  logic ram_we;
  logic div_start;
  logic out_load;
  logic ring_full;

  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old_s;
  logic signed [SAMPLE_BITS-1:0] div_quo;
  sma_div_stat_t                 div_stat;

  assign in_fire   = in_chan.valid && in_ready;
  assign ring_full = (fill_r == CNT_BITS'(WINDOW));

  // Ring storage. Read at accept, written back in the UPDATE state that follows;
  // the FSM never overlaps a read and a write of the same item.
  sma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // slot == fill until the ring is full, so an unfilled slot reads as zero
  assign old_s = ring_full ? $signed(ram_rdata) : '0;

  sma_div #(
    .DIVIDEND_BITS (TOT_BITS),
    .DIVISOR_BITS  (CNT_BITS),
    .QUO_BITS      (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_nxt),
    .divisor  (fill_nxt),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_DIV;
      ST_DIV:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_re   = in_chan.valid;
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV: begin
        // hand the quotient over once the output register is free
        out_load = div_stat.done && (!out_valid_r || out_chan.ready);
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    sample_nxt    = in_fire ? in_chan.sample : sample_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    out_avg_nxt   = out_avg_r;
    out_valid_nxt = out_valid_r;
    if (state_r == ST_UPDATE) begin
      // drop the overwritten entry, add the new one
      total_nxt = total_r - TOT_BITS'(old_s) + TOT_BITS'(sample_r);
      slot_nxt  = (slot_r == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_r + SLOT_BITS'(1);
      fill_nxt  = ring_full ? fill_r : fill_r + CNT_BITS'(1);
    end
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_avg_nxt   = div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    out_avg_r <= out_avg_nxt;
  end

  assign in_chan.ready    = in_ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.average = out_avg_r;

  `SMA_ASSERT_NEXT(a_accept_to_update, in_chan.valid && in_chan.ready,
                   state_r == ST_UPDATE, "accepted item did not reach UPDATE")
  `SMA_ASSERT_NEXT(a_update_starts_div, state_r == ST_UPDATE,
                   div_stat.busy && !div_stat.done, "divider not started on update")
  `SMA_ASSERT_NOW(a_slot_tracks_fill, !ring_full,
                  slot_r == SLOT_BITS'(fill_r), "write slot out of step with fill count")
  `SMA_ASSERT_NOW(a_fill_bound, 1'b1,
                  fill_r <= CNT_BITS'(WINDOW), "fill count beyond window")

endmodule

@@ test/simple_moving_average_test.sv @@
// Testbench for simple_moving_average: directed sample table, then random samples.
// Checks each average against an in-bench running-average predictor.
// Depends on sma_pkg, sma_in_if/sma_out_if and the simple_moving_average RTL.
`timescale 1ns / 100ps

module simple_moving_average_test;

  localparam int WINDOW       = sma_pkg::WINDOW_DEF;
  localparam int SAMPLE_BITS  = sma_pkg::SAMPLE_BITS_DEF;
  localparam int SLOT_BITS    = $clog2(WINDOW);
  // exact sum of a full ring: WINDOW times the largest magnitude
  localparam int TOTAL_BITS   = SAMPLE_BITS + SLOT_BITS;

  localparam int RANDOM_ITEMS = 1527;
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES  = 40;    // settling time after the final drain

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // one row of the directed table; typed rows carry a hand-worked average
  typedef struct packed {
    sample_t sample;
    logic    typed;
    sample_t average;
  } sample_row_t;

  localparam int DIRECTED_COUNT = 23;

  // Rows 3..18 fill the whole ring with the most negative sample, so the
  // last of them must average to exactly that value (sum at its 20-bit floor).
  localparam sample_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{SAMPLE_MAX, 1'b1, SAMPLE_MAX},     // first item after reset: divisor is one
    '{SAMPLE_MIN, 1'b1, sample_t'(0)},   // -1 / 2 truncates toward zero
    '{sample_t'(0), 1'b0, '0},           // partly filled ring, divisor three
    '{SAMPLE_MIN, 1'b0, '0}, '{SAMPLE_MIN, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, '0}, '{SAMPLE_MIN, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, '0}, '{SAMPLE_MIN, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, '0}, '{SAMPLE_MIN, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, '0}, '{SAMPLE_MIN, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, '0}, '{SAMPLE_MIN, 1'b0, '0},
    '{SAMPLE_MIN, 1'b0, '0}, '{SAMPLE_MIN, 1'b0, '0},  // ring wraps here
    '{SAMPLE_MIN, 1'b0, '0},
    '{SAMPLE_MIN, 1'b1, SAMPLE_MIN},     // ring full of the minimum
    '{16'sh5555, 1'b0, '0},              // alternating bit patterns
    '{16'shaaaa, 1'b0, '0},
    '{sample_t'(1), 1'b0, '0},
    '{sample_t'(-1), 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  sma_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_chan ();
  sma_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_chan ();

  simple_moving_average #(
    .WINDOW     (WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // predictor state, mirrors the block's ring after reset
  sample_t                       window_ring [WINDOW];
  logic [SLOT_BITS-1:0]          ring_slot;
  logic [SLOT_BITS:0]            samples_held;
  logic signed [TOTAL_BITS-1:0]  window_total;

  sample_t expected_averages [$];
  int      error_count;
  int      samples_taken;     // items accepted on the input side so far
  int      quiet_cycles;

  // pacing flags shared by the sender and the receiver
  bit      steady;            // no idling on either side
  bit      hold_off_req;      // receiver stops taking results for a while

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Advance the running average by one sample: drop the entry about to be
  // overwritten, add the new one, divide by the samples held (truncating).
  function automatic sample_t next_average(input sample_t sample);
    window_total = window_total - window_ring[ring_slot] + sample;
    window_ring[ring_slot] = sample;
    ring_slot = (ring_slot == SLOT_BITS'(WINDOW - 1)) ? '0 : ring_slot + 1'b1;
    if (samples_held < WINDOW)
      samples_held = samples_held + 1'b1;
    return sample_t'(int'(window_total) / int'(samples_held));
  endfunction

  // Offer one sample, idling first at random unless a steady stretch or a
  // hold-off is running; returns at the falling edge after the accept.
  task automatic push_sample(input sample_t sample);
    while (!steady && !hold_off_req && $urandom_range(0, 99) < 34) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.sample <= sample;
    @(posedge clk);
    while (!in_chan.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering until every outstanding average has come back.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do
      @(negedge clk);
    while (expected_averages.size() != 0);
  endtask

  // Monitor: predict on each accepted sample, check each accepted average,
  // and count cycles in which nothing moves for the watchdog.
  always @(posedge clk) begin : monitor
    sample_t predicted;
    sample_t wanted;
    bit      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        predicted = next_average(in_chan.sample);
        // typed rows check the predictor's arithmetic as well as the block
        if (samples_taken < DIRECTED_COUNT && DIRECTED_ROWS[samples_taken].typed)
          expected_averages.push_back(DIRECTED_ROWS[samples_taken].average);
        else
          expected_averages.push_back(predicted);
        samples_taken++;
        moved = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        moved = 1'b1;
        if (expected_averages.size() == 0) begin
          $error("average: no item expected, actual %0d", out_chan.average);
          error_count++;
        end else begin
          wanted = expected_averages.pop_front();
          if (out_chan.average !== wanted) begin
            $error("average: expected %0d, actual %0d", wanted, out_chan.average);
            error_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random backpressure, steady stretches, and one long hold-off
  // counted here so the block fills up and stops taking samples.
  initial begin : receiver
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_chan.ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Sender: reset, directed table, then random samples.
  initial begin : stimulus
    int      row;
    int      sent;
    int      mode;
    int      burst_left;
    sample_t sample;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    steady         = 1'b0;
    hold_off_req   = 1'b0;
    error_count    = 0;
    samples_taken  = 0;
    quiet_cycles   = 0;
    burst_left     = 0;
    sample         = '0;
    for (row = 0; row < WINDOW; row++)
      window_ring[row] = '0;
    ring_slot    = '0;
    samples_held = '0;
    window_total = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < DIRECTED_COUNT; row++)
      push_sample(DIRECTED_ROWS[row].sample);
    wait_drained();

    for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
      if (sent == 300)
        hold_off_req = 1'b1;
      steady = (sent >= 700 && sent < 1000);
      if (sent == 1200)
        wait_drained();

      // bursts repeat the last sample long enough to fill the ring
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        mode = $urandom_range(0, 19);
        if (mode < 12) begin
          sample = sample_t'($urandom);
        end else if (mode < 14) begin
          sample = sample_t'(int'($urandom_range(0, 8)) - 4);
        end else if (mode == 14) begin
          sample     = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
          burst_left = WINDOW - 1 + $urandom_range(0, 4);
        end else if (mode == 15) begin
          sample = SAMPLE_MAX;
        end else if (mode == 16) begin
          sample = SAMPLE_MIN;
        end else begin
          // close to either extreme
          sample = $urandom_range(0, 1) ? SAMPLE_MAX - sample_t'($urandom_range(0, 15))
                                        : SAMPLE_MIN + sample_t'($urandom_range(0, 15));
        end
      end
      push_sample(sample);
    end
    steady = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/sma_pkg.sv
rtl/core/sma_if.sv
rtl/core/sma_ram.sv
rtl/core/sma_div.sv
rtl/core/simple_moving_average.sv
test/simple_moving_average_test.sv
